@@ rtl/cbs_pkg.sv @@
package cbs_pkg;

	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;
	localparam int TIME_BITS = 24;
	localparam int MUL_BITS  = (WORD_BITS + 3 > TIME_BITS + 1) ? WORD_BITS + 3 : TIME_BITS + 1;
	localparam int PROD_BITS = 2 * MUL_BITS;
	localparam int QUO_BITS  = WORD_BITS + 2;
	localparam int NUM_BITS  = 3 * WORD_BITS + 4;
	localparam int REM_BITS  = 2 * WORD_BITS + 3;
	localparam int CNT_BITS  = $clog2(QUO_BITS + 1);

	localparam logic [1:0] REQ_LOAD     = 2'd0;
	localparam logic [1:0] REQ_NEIGHBOR = 2'd1;
	localparam logic [1:0] REQ_MOVE     = 2'd2;
	localparam logic [1:0] REQ_NONE     = 2'd3;

	localparam logic [1:0] REG_LEFT   = 2'd0;
	localparam logic [1:0] REG_RIGHT  = 2'd1;
	localparam logic [1:0] REG_TOP    = 2'd2;
	localparam logic [1:0] REG_BOTTOM = 2'd3;

	typedef struct packed {
		logic [1:0]                  req_type;
		logic signed [WORD_BITS-1:0] pos_x;
		logic signed [WORD_BITS-1:0] pos_y;
		logic [WORD_BITS-2:0]        radius;
		logic signed [WORD_BITS-1:0] vel_x;
		logic signed [WORD_BITS-1:0] vel_y;
		logic [TIME_BITS-1:0]        time_step;
	} req_t;

	typedef struct packed {
		logic signed [WORD_BITS-1:0] out_pos_x;
		logic signed [WORD_BITS-1:0] out_pos_y;
		logic signed [WORD_BITS-1:0] out_vel_x;
		logic signed [WORD_BITS-1:0] out_vel_y;
		logic                        bounced;
	} rsp_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_DISPATCH, ST_LOAD, ST_WALL_X, ST_WALL_Y,
		ST_NB_DIFF, ST_NB_M1, ST_NB_M2, ST_NB_M3, ST_NB_M4, ST_NB_M5, ST_NB_A5, ST_NB_CHK,
		ST_RF_M1, ST_RF_M2, ST_RF_A2, ST_RF_INIT, ST_RF_DIV, ST_RF_APPLY,
		ST_MV_M1, ST_MV_M2, ST_MV_A2, ST_FIN
	} state_t;

	typedef enum logic [3:0] {
		MUL_DXDX, MUL_DYDY, MUL_RSRS, MUL_VXDX, MUL_VYDY,
		MUL_LO, MUL_HI, MUL_VXDT, MUL_VYDT
	} mul_sel_t;

	typedef enum logic [3:0] {
		ACC_NONE, ACC_DD_SET, ACC_DD_ADD, ACC_LIM, ACC_DOT_SET, ACC_DOT_ADD,
		ACC_NUM_SET, ACC_NUM_ADD, ACC_MOVE_X, ACC_MOVE_Y
	} acc_sel_t;

	typedef struct packed {
		logic     capture;
		logic     load;
		logic     wall_x;
		logic     wall_y;
		logic     diff;
		mul_sel_t mul_sel;
		acc_sel_t acc_sel;
		logic     div_init;
		logic     div_step;
		logic     refl;
		logic     axis;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic       collide;
		logic       out_free;
	} sts_t;

	function automatic logic signed [PROD_BITS-1:0] ext_w(input logic signed [WORD_BITS-1:0] v);
		return {{(PROD_BITS-WORD_BITS){v[WORD_BITS-1]}}, v};
	endfunction

	function automatic logic signed [WORD_BITS-1:0] sat_w(input logic signed [PROD_BITS-1:0] v);
		logic [PROD_BITS-WORD_BITS:0] upper;
		upper = v[PROD_BITS-1:WORD_BITS-1];
		if ((&upper) || !(|upper)) begin
			return v[WORD_BITS-1:0];
		end else if (v[PROD_BITS-1]) begin
			return {1'b1, {(WORD_BITS-1){1'b0}}};
		end else begin
			return {1'b0, {(WORD_BITS-1){1'b1}}};
		end
	endfunction

endpackage

@@ rtl/cbs_ctrl.sv @@
module cbs_ctrl import cbs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  sts_t sts,
	output cmd_t cmd,
	output logic req_ready
);

	state_t              state_q, state_d;
	logic                axis_q;
	logic [CNT_BITS-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_NB_CHK) axis_q <= 1'b0;
			if (state_q == ST_RF_APPLY) axis_q <= 1'b1;
			if (state_q == ST_RF_INIT) cnt_q <= '0;
			if (state_q == ST_RF_DIV) cnt_q <= cnt_q + 1'b1;
		end
	end

	always_comb begin
		cmd       = '0;
		cmd.axis  = axis_q;
		req_ready = 1'b0;
		state_d   = state_q;
		unique case (state_q)
			ST_IDLE: begin
				req_ready   = 1'b1;
				cmd.capture = req_valid;
				if (req_valid) state_d = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				unique case (sts.req_type)
					REQ_LOAD:     state_d = ST_LOAD;
					REQ_NEIGHBOR: state_d = ST_NB_DIFF;
					REQ_MOVE:     state_d = ST_MV_M1;
					default:      state_d = ST_FIN;
				endcase
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				state_d  = ST_WALL_X;
			end
			ST_WALL_X: begin
				cmd.wall_x = 1'b1;
				state_d    = ST_WALL_Y;
			end
			ST_WALL_Y: begin
				cmd.wall_y = 1'b1;
				state_d    = ST_FIN;
			end
			ST_NB_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = ST_NB_M1;
			end
			ST_NB_M1: begin
				cmd.mul_sel = MUL_DXDX;
				state_d     = ST_NB_M2;
			end
			ST_NB_M2: begin
				cmd.mul_sel = MUL_DYDY;
				cmd.acc_sel = ACC_DD_SET;
				state_d     = ST_NB_M3;
			end
			ST_NB_M3: begin
				cmd.mul_sel = MUL_RSRS;
				cmd.acc_sel = ACC_DD_ADD;
				state_d     = ST_NB_M4;
			end
			ST_NB_M4: begin
				cmd.mul_sel = MUL_VXDX;
				cmd.acc_sel = ACC_LIM;
				state_d     = ST_NB_M5;
			end
			ST_NB_M5: begin
				cmd.mul_sel = MUL_VYDY;
				cmd.acc_sel = ACC_DOT_SET;
				state_d     = ST_NB_A5;
			end
			ST_NB_A5: begin
				cmd.acc_sel = ACC_DOT_ADD;
				state_d     = ST_NB_CHK;
			end
			ST_NB_CHK: begin
				state_d = sts.collide ? ST_RF_M1 : ST_FIN;
			end
			ST_RF_M1: begin
				cmd.mul_sel = MUL_LO;
				state_d     = ST_RF_M2;
			end
			ST_RF_M2: begin
				cmd.mul_sel = MUL_HI;
				cmd.acc_sel = ACC_NUM_SET;
				state_d     = ST_RF_A2;
			end
			ST_RF_A2: begin
				cmd.acc_sel = ACC_NUM_ADD;
				state_d     = ST_RF_INIT;
			end
			ST_RF_INIT: begin
				cmd.div_init = 1'b1;
				state_d      = ST_RF_DIV;
			end
			ST_RF_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CNT_BITS'(QUO_BITS - 1)) state_d = ST_RF_APPLY;
			end
			ST_RF_APPLY: begin
				cmd.refl = 1'b1;
				state_d  = axis_q ? ST_FIN : ST_RF_M1;
			end
			ST_MV_M1: begin
				cmd.mul_sel = MUL_VXDT;
				state_d     = ST_MV_M2;
			end
			ST_MV_M2: begin
				cmd.mul_sel = MUL_VYDT;
				cmd.acc_sel = ACC_MOVE_X;
				state_d     = ST_MV_A2;
			end
			ST_MV_A2: begin
				cmd.acc_sel = ACC_MOVE_Y;
				state_d     = ST_FIN;
			end
			ST_FIN: begin
				cmd.out_load = sts.out_free;
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

@@ rtl/cbs_dp.sv @@
module cbs_dp import cbs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  req_t                 req_data,
	input  logic                 wr_en,
	input  logic [1:0]           wr_index,
	input  logic [WORD_BITS-1:0] wr_data,
	input  logic                 rsp_ready,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	output logic                 rsp_valid,
	output rsp_t                 rsp_data
);

	localparam int W = WORD_BITS;

	req_t                   in_q;
	logic signed [W-1:0]    left_q, right_q, top_q, bottom_q;
	logic signed [W-1:0]    cur_x_q, cur_y_q, cur_vx_q, cur_vy_q;
	logic [W-2:0]           cur_r_q;
	logic signed [W:0]      dx_q, dy_q;
	logic [W-1:0]           rs_q;
	logic signed [PROD_BITS-1:0] prod_q, dd_q, lim_q, dot_q;
	logic [NUM_BITS-1:0]    num_q;
	logic [REM_BITS-1:0]    rem_q;
	logic [QUO_BITS-1:0]    nsh_q, quo_q;
	logic                   hit_q;
	rsp_t                   rsp_q;
	logic                   rsp_valid_q;

	logic signed [MUL_BITS-1:0]  mul_a, mul_b;
	logic signed [W:0]           d_sel;
	logic [W:0]                  d_mag;
	logic [W+1:0]                d_two;
	logic signed [PROD_BITS-1:0] delta, r_ext, vx1, vy1, v_sel, v_new, q_ext;
	logic [REM_BITS-1:0]         trial, dd_r;
	logic                        hx, lx, hy, ly;

	assign d_sel = cmd.axis ? dy_q : dx_q;
	assign d_mag = d_sel[W] ? (W+1)'(0) - d_sel : d_sel;
	assign d_two = {d_mag, 1'b0};

	always_comb begin
		unique case (cmd.mul_sel)
			MUL_DXDX: begin
				mul_a = {{(MUL_BITS-W-1){dx_q[W]}}, dx_q};
				mul_b = mul_a;
			end
			MUL_DYDY: begin
				mul_a = {{(MUL_BITS-W-1){dy_q[W]}}, dy_q};
				mul_b = mul_a;
			end
			MUL_RSRS: begin
				mul_a = {{(MUL_BITS-W){1'b0}}, rs_q};
				mul_b = mul_a;
			end
			MUL_VXDX: begin
				mul_a = {{(MUL_BITS-W){cur_vx_q[W-1]}}, cur_vx_q};
				mul_b = {{(MUL_BITS-W-1){dx_q[W]}}, dx_q};
			end
			MUL_VYDY: begin
				mul_a = {{(MUL_BITS-W){cur_vy_q[W-1]}}, cur_vy_q};
				mul_b = {{(MUL_BITS-W-1){dy_q[W]}}, dy_q};
			end
			MUL_LO: begin
				mul_a = {{(MUL_BITS-W-1){1'b0}}, dot_q[W:0]};
				mul_b = {{(MUL_BITS-W-2){1'b0}}, d_two};
			end
			MUL_HI: begin
				mul_a = {{(MUL_BITS-W-1){1'b0}}, dot_q[2*W+1:W+1]};
				mul_b = {{(MUL_BITS-W-2){1'b0}}, d_two};
			end
			MUL_VXDT: begin
				mul_a = {{(MUL_BITS-W){cur_vx_q[W-1]}}, cur_vx_q};
				mul_b = {{(MUL_BITS-TIME_BITS){1'b0}}, in_q.time_step};
			end
			MUL_VYDT: begin
				mul_a = {{(MUL_BITS-W){cur_vy_q[W-1]}}, cur_vy_q};
				mul_b = {{(MUL_BITS-TIME_BITS){1'b0}}, in_q.time_step};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// truncate the scaled step toward zero
	assign delta = prod_q[PROD_BITS-1]
		? (prod_q + PROD_BITS'((1 << FRAC_BITS) - 1)) >>> FRAC_BITS
		: prod_q >>> FRAC_BITS;

	// wall checks in order right, left, bottom, top
	assign r_ext = {{(PROD_BITS-W+1){1'b0}}, cur_r_q};
	assign hx  = (ext_w(cur_x_q) + r_ext > ext_w(right_q)) && (cur_vx_q > 0);
	assign vx1 = hx ? ext_w(sat_w(-ext_w(cur_vx_q))) : ext_w(cur_vx_q);
	assign lx  = (ext_w(cur_x_q) - r_ext < ext_w(left_q)) && (vx1 < 0);
	assign hy  = (ext_w(cur_y_q) + r_ext > ext_w(bottom_q)) && (cur_vy_q > 0);
	assign vy1 = hy ? ext_w(sat_w(-ext_w(cur_vy_q))) : ext_w(cur_vy_q);
	assign ly  = (ext_w(cur_y_q) - r_ext < ext_w(top_q)) && (vy1 < 0);

	assign dd_r  = dd_q[REM_BITS-1:0];
	assign trial = {rem_q[REM_BITS-2:0], nsh_q[QUO_BITS-1]};

	assign v_sel = cmd.axis ? ext_w(cur_vy_q) : ext_w(cur_vx_q);
	assign q_ext = {{(PROD_BITS-QUO_BITS){1'b0}}, quo_q};
	assign v_new = d_sel[W] ? v_sel + q_ext : v_sel - q_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q      <= '0;
			right_q     <= {1'b0, {(W-1){1'b1}}};
			top_q       <= '0;
			bottom_q    <= {1'b0, {(W-1){1'b1}}};
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			cur_vx_q    <= '0;
			cur_vy_q    <= '0;
			cur_r_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				unique case (wr_index)
					REG_LEFT:   left_q   <= wr_data;
					REG_RIGHT:  right_q  <= wr_data;
					REG_TOP:    top_q    <= wr_data;
					REG_BOTTOM: bottom_q <= wr_data;
					default:    left_q   <= left_q;
				endcase
			end
			if (cmd.load) begin
				cur_x_q  <= in_q.pos_x;
				cur_y_q  <= in_q.pos_y;
				cur_r_q  <= in_q.radius;
				cur_vx_q <= in_q.vel_x;
				cur_vy_q <= in_q.vel_y;
			end
			if (cmd.wall_x) cur_vx_q <= lx ? sat_w(-vx1) : vx1[W-1:0];
			if (cmd.wall_y) cur_vy_q <= ly ? sat_w(-vy1) : vy1[W-1:0];
			if (cmd.acc_sel == ACC_MOVE_X) cur_x_q <= sat_w(ext_w(cur_x_q) + delta);
			if (cmd.acc_sel == ACC_MOVE_Y) cur_y_q <= sat_w(ext_w(cur_y_q) + delta);
			if (cmd.refl) begin
				if (cmd.axis) cur_vy_q <= sat_w(v_new);
				else cur_vx_q <= sat_w(v_new);
			end
			if (cmd.out_load) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (cmd.capture) begin
			in_q  <= req_data;
			hit_q <= 1'b0;
		end
		if (cmd.wall_x && (hx || lx)) hit_q <= 1'b1;
		if (cmd.wall_y && (hy || ly)) hit_q <= 1'b1;
		if (cmd.refl) hit_q <= 1'b1;
		if (cmd.diff) begin
			dx_q <= {in_q.pos_x[W-1], in_q.pos_x} - {cur_x_q[W-1], cur_x_q};
			dy_q <= {in_q.pos_y[W-1], in_q.pos_y} - {cur_y_q[W-1], cur_y_q};
			rs_q <= {1'b0, in_q.radius} + {1'b0, cur_r_q};
		end
		unique case (cmd.acc_sel)
			ACC_DD_SET:  dd_q  <= prod_q;
			ACC_DD_ADD:  dd_q  <= dd_q + prod_q;
			ACC_LIM:     lim_q <= prod_q;
			ACC_DOT_SET: dot_q <= prod_q;
			ACC_DOT_ADD: dot_q <= dot_q + prod_q;
			ACC_NUM_SET: num_q <= {{(NUM_BITS-PROD_BITS){1'b0}}, prod_q};
			ACC_NUM_ADD: num_q <= num_q + ({{(NUM_BITS-PROD_BITS){1'b0}}, prod_q} << (W + 1));
			default:     num_q <= num_q;
		endcase
		if (cmd.div_init) begin
			rem_q <= {1'b0, num_q[NUM_BITS-1:QUO_BITS]};
			nsh_q <= num_q[QUO_BITS-1:0];
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			nsh_q <= nsh_q << 1;
			if (trial >= dd_r) begin
				rem_q <= trial - dd_r;
				quo_q <= {quo_q[QUO_BITS-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[QUO_BITS-2:0], 1'b0};
			end
		end
		if (cmd.out_load) begin
			rsp_q.out_pos_x <= cur_x_q;
			rsp_q.out_pos_y <= cur_y_q;
			rsp_q.out_vel_x <= cur_vx_q;
			rsp_q.out_vel_y <= cur_vy_q;
			rsp_q.bounced   <= hit_q;
		end
	end

	assign sts.req_type = in_q.req_type;
	assign sts.collide  = (dd_q < lim_q) && (dot_q > 0);
	assign sts.out_free = !rsp_valid_q || rsp_ready;
	assign rsp_valid    = rsp_valid_q;
	assign rsp_data     = rsp_q;

endmodule

@@ rtl/circle_bounce_step_top.sv @@
// One transaction at a time: req_ready is high only while the controller is idle.
// From accept to rsp_valid a load runs the wall checks, a move its two scaled steps,
// an unused code goes straight to the output, a neighbor that misses stops after the
// collision check, and one that reflects runs two divides with a 34-bit quotient each.
// A waiting result sits in the output register; the next request is taken meanwhile.
// Reset (arst_n low, asynchronous) clears the circle to zero, walls to 0 / largest word.
module circle_bounce_step_top import cbs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  req_t                 req_data,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output rsp_t                 rsp_data,
	input  logic                 wr_en,
	input  logic [1:0]           wr_index,
	input  logic [WORD_BITS-1:0] wr_data
);

	cmd_t cmd;
	sts_t sts;

	// sequencer: walks load, neighbor, move and unused-code transactions through the datapath
	cbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.sts       (sts),
		.cmd       (cmd),
		.req_ready (req_ready)
	);

	// datapath: circle state, wall registers, shared multiplier, divider, output register
	cbs_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req_data),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.rsp_ready (rsp_ready),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_data  (rsp_data)
	);

	// only one transaction in flight
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request accepted while another is in flight");

	// never overwrite a result that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!rsp_valid || rsp_ready))
		else $error("output register overwritten");

	// a reflection never comes straight after a capture
	a_refl_after_hit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> !cmd.refl)
		else $error("reflection issued without a collision check");

endmodule

@@ tb/circle_bounce_step_top_tb.sv @@
`timescale 1ns / 1ps

module circle_bounce_step_top_tb;
	import cbs_pkg::*;

	typedef logic signed [127:0] wide_t;

	localparam logic signed [31:0] W_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] W_MIN = 32'sh80000000;
	localparam int UNIT       = 1 << 16;
	localparam int STALL_MAX  = 3000;
	localparam int DRAIN_WAIT = 120;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req_data = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp_data;
	logic wr_en = 1'b0;
	logic [1:0] wr_index = REG_LEFT;
	logic [WORD_BITS-1:0] wr_data = '0;

	circle_bounce_step_top u_top (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// shadow of the circle and the walls
	logic signed [31:0] wall_l, wall_r, wall_t, wall_b;
	logic signed [31:0] cur_x, cur_y, cur_vx, cur_vy;
	logic [30:0] cur_rad;

	req_t req_pending_q[$];
	rsp_t want_rsp_q[$];
	int n_queued = 0, n_sent = 0, n_checked = 0, n_bounced = 0, n_errors = 0;
	int n_reflect = 0, n_walls = 0;
	int send_gap = 0, recv_gap = 0, hold_left = 0;
	int hold_req = 0, hold_seen = 0;
	int idle_cycles = 0;
	bit quiet = 1'b0;

	function automatic logic signed [31:0] clamp_w(input wide_t v);
		if (v > wide_t'(W_MAX)) return W_MAX;
		if (v < wide_t'(W_MIN)) return W_MIN;
		return v[31:0];
	endfunction

	function automatic wide_t mag_w(input wide_t v);
		return (v < 0) ? -v : v;
	endfunction

	// magnitude of the scaled move step, capped at 2^32 (the sum is clamped afterwards anyway)
	function automatic wide_t move_delta(input logic signed [31:0] v, input logic [23:0] dt);
		wide_t p;
		p = (mag_w(wide_t'(v)) * wide_t'({1'b0, dt})) >>> FRAC_BITS;
		if (p > (wide_t'(1) <<< 32)) p = wide_t'(1) <<< 32;
		return p;
	endfunction

	function automatic logic signed [31:0] reflect_comp(input logic signed [31:0] v,
			input wide_t d, input wide_t dot, input wide_t dd);
		wide_t q;
		q = (2 * dot * mag_w(d)) / dd;
		return clamp_w((d < 0) ? wide_t'(v) + q : wide_t'(v) - q);
	endfunction

	// advance the circle shadow by one transaction and return its result
	function automatic rsp_t advance_circle(input req_t q);
		rsp_t e;
		logic hit;
		wide_t rr, dx, dy, dd, rs, dot;
		logic signed [31:0] nvx, nvy;
		hit = 1'b0;
		case (q.req_type)
			REQ_LOAD: begin
				cur_x = q.pos_x;
				cur_y = q.pos_y;
				cur_rad = q.radius;
				cur_vx = q.vel_x;
				cur_vy = q.vel_y;
				rr = wide_t'({1'b0, cur_rad});
				// each wall sees what the previous one left
				if (wide_t'(cur_x) + rr > wide_t'(wall_r) && cur_vx > 0) begin
					cur_vx = clamp_w(-wide_t'(cur_vx)); hit = 1'b1;
				end
				if (wide_t'(cur_x) - rr < wide_t'(wall_l) && cur_vx < 0) begin
					cur_vx = clamp_w(-wide_t'(cur_vx)); hit = 1'b1;
				end
				if (wide_t'(cur_y) + rr > wide_t'(wall_b) && cur_vy > 0) begin
					cur_vy = clamp_w(-wide_t'(cur_vy)); hit = 1'b1;
				end
				if (wide_t'(cur_y) - rr < wide_t'(wall_t) && cur_vy < 0) begin
					cur_vy = clamp_w(-wide_t'(cur_vy)); hit = 1'b1;
				end
				if (hit) n_walls++;
			end
			REQ_NEIGHBOR: begin
				dx = wide_t'(q.pos_x) - wide_t'(cur_x);
				dy = wide_t'(q.pos_y) - wide_t'(cur_y);
				dd = dx * dx + dy * dy;
				rs = wide_t'({1'b0, q.radius}) + wide_t'({1'b0, cur_rad});
				dot = wide_t'(cur_vx) * dx + wide_t'(cur_vy) * dy;
				if (dd < rs * rs && dot > 0 && dd != 0) begin
					nvx = reflect_comp(cur_vx, dx, dot, dd);
					nvy = reflect_comp(cur_vy, dy, dot, dd);
					cur_vx = nvx;
					cur_vy = nvy;
					hit = 1'b1;
					n_reflect++;
				end
			end
			REQ_MOVE: begin
				cur_x = clamp_w((cur_vx < 0) ? wide_t'(cur_x) - move_delta(cur_vx, q.time_step)
					: wide_t'(cur_x) + move_delta(cur_vx, q.time_step));
				cur_y = clamp_w((cur_vy < 0) ? wide_t'(cur_y) - move_delta(cur_vy, q.time_step)
					: wide_t'(cur_y) + move_delta(cur_vy, q.time_step));
			end
			default: ;
		endcase
		e.out_pos_x = cur_x;
		e.out_pos_y = cur_y;
		e.out_vel_x = cur_vx;
		e.out_vel_y = cur_vy;
		e.bounced = hit;
		return e;
	endfunction

	// mostly short gaps, a few long ones, none while quiet
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// driver: offer pending transactions, predict each one as it is accepted
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready) begin
				want_rsp_q.push_back(advance_circle(req_data));
				n_sent++;
			end
			if (!req_valid || req_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					req_valid <= 1'b0;
				end else if (req_pending_q.size() > 0) begin
					req_valid <= 1'b1;
					req_data <= req_pending_q.pop_front();
					send_gap = pick_gap();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each result against the oldest prediction, stall at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (want_rsp_q.size() == 0) begin
					n_errors++;
					if (n_errors <= 10) $display("unexpected result %h", rsp_data);
				end else begin
					rsp_t e;
					e = want_rsp_q.pop_front();
					n_checked++;
					if (e.bounced) n_bounced++;
					if (e.out_pos_x !== rsp_data.out_pos_x || e.out_pos_y !== rsp_data.out_pos_y
							|| e.out_vel_x !== rsp_data.out_vel_x
							|| e.out_vel_y !== rsp_data.out_vel_y
							|| e.bounced !== rsp_data.bounced) begin
						n_errors++;
						if (n_errors <= 10)
							$display("mismatch #%0d: exp pos %h %h vel %h %h b %b, got pos %h %h vel %h %h b %b",
								n_checked, e.out_pos_x, e.out_pos_y, e.out_vel_x, e.out_vel_y,
								e.bounced, rsp_data.out_pos_x, rsp_data.out_pos_y,
								rsp_data.out_vel_x, rsp_data.out_vel_y, rsp_data.bounced);
					end
				end
			end
			// a long hold-off, so the block backs up into its input
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
				recv_gap = pick_gap();
			end
		end
	end

	// watchdog: count cycles with no transaction on either side
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_MAX) begin
			$display("watchdog expired after %0d idle cycles", idle_cycles);
			$display("circle_bounce_step_top test failed");
			$finish;
		end
	end

	task automatic write_wall(input logic [1:0] idx, input logic signed [31:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		case (idx)
			REG_LEFT:   wall_l = val;
			REG_RIGHT:  wall_r = val;
			REG_TOP:    wall_t = val;
			default:    wall_b = val;
		endcase
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic set_walls(input logic signed [31:0] l, input logic signed [31:0] r,
			input logic signed [31:0] t, input logic signed [31:0] b);
		write_wall(REG_LEFT, l);
		write_wall(REG_RIGHT, r);
		write_wall(REG_TOP, t);
		write_wall(REG_BOTTOM, b);
	endtask

	task automatic queue_req(input logic [1:0] kind, input logic signed [31:0] x,
			input logic signed [31:0] y, input logic [30:0] r, input logic signed [31:0] vx,
			input logic signed [31:0] vy, input logic [23:0] dt);
		req_t q;
		q.req_type = kind;
		q.pos_x = x;
		q.pos_y = y;
		q.radius = r;
		q.vel_x = vx;
		q.vel_y = vy;
		q.time_step = dt;
		req_pending_q.push_back(q);
		n_queued++;
	endtask

	// hold until every queued transaction is answered
	task automatic drain();
		while (n_sent != n_queued || want_rsp_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	function automatic logic signed [31:0] pick_coord();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return $urandom;
		if (r == 1) begin
			case ($urandom_range(0, 4))
				0: return W_MAX;
				1: return W_MIN;
				2: return 0;
				3: return -1;
				default: return 1;
			endcase
		end
		return $signed($urandom_range(0, 200 * UNIT)) - 100 * UNIT;
	endfunction

	function automatic logic signed [31:0] pick_vel();
		if ($urandom_range(0, 9) == 0) return $urandom;
		return $signed($urandom_range(0, 16 * UNIT)) - 8 * UNIT;
	endfunction

	// a load followed by neighbors and moves around it, with some noise
	task automatic queue_burst();
		logic signed [31:0] cx, cy;
		logic [30:0] rad;
		int span, k;
		cx = pick_coord();
		cy = pick_coord();
		rad = ($urandom_range(0, 15) == 0) ? 31'($urandom) : 31'($urandom_range(1, 20 * UNIT));
		queue_req(REQ_LOAD, cx, cy, rad, pick_vel(), pick_vel(), $urandom);
		span = (rad > 20 * UNIT) ? 40 * UNIT : int'(rad);
		repeat ($urandom_range(1, 6)) begin
			k = $urandom_range(0, 9);
			if (k < 5)
				queue_req(REQ_NEIGHBOR,
					32'(longint'(cx) + $urandom_range(0, 4 * span) - 2 * span),
					32'(longint'(cy) + $urandom_range(0, 4 * span) - 2 * span),
					31'($urandom_range(0, 2 * span)), $urandom, $urandom, $urandom);
			else if (k < 8)
				queue_req(REQ_MOVE, $urandom, $urandom, $urandom, $urandom, $urandom,
					($urandom_range(0, 7) == 0) ? 24'($urandom) : 24'($urandom_range(0, UNIT)));
			else
				queue_req(2'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom);
		end
	endtask

	task automatic queue_random(input int count);
		int goal;
		goal = n_queued + count;
		while (n_queued < goal) queue_burst();
	endtask

	initial begin
		wall_l = 0; wall_r = W_MAX; wall_t = 0; wall_b = W_MAX;
		cur_x = 0; cur_y = 0; cur_vx = 0; cur_vy = 0; cur_rad = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, wall hits, cancelling hits, neighbor cases, move limits
		queue_req(REQ_MOVE, 0, 0, 0, 0, 0, 24'hffffff);
		queue_req(REQ_LOAD, 0, 0, 0, 0, 0, 0);
		queue_req(REQ_LOAD, W_MAX, W_MAX, 31'h7fffffff, W_MAX, W_MAX, 0);
		queue_req(REQ_LOAD, W_MIN, W_MIN, 5 * UNIT, W_MIN, W_MIN, 0);
		queue_req(REQ_MOVE, 0, 0, 0, 0, 0, 24'hffffff);
		queue_req(REQ_LOAD, W_MAX - 1, 10 * UNIT, 31'h7fffffff, 5, 0, 0);
		queue_req(REQ_LOAD, 10 * UNIT, 10 * UNIT, 2 * UNIT, UNIT, 0, 0);
		queue_req(REQ_NEIGHBOR, 10 * UNIT, 10 * UNIT, 2 * UNIT, 0, 0, 0);
		queue_req(REQ_NEIGHBOR, 12 * UNIT, 11 * UNIT, UNIT, 0, 0, 0);
		queue_req(REQ_NEIGHBOR, 1000 * UNIT, 10 * UNIT, UNIT, 0, 0, 0);
		queue_req(REQ_NEIGHBOR, 12 * UNIT, 10 * UNIT, UNIT, 0, 0, 0);
		queue_req(REQ_NEIGHBOR, W_MIN, W_MAX, 31'h7fffffff, 0, 0, 0);
		queue_req(REQ_MOVE, 0, 0, 0, 0, 0, 0);
		queue_req(REQ_MOVE, 0, 0, 0, 0, 0, 1);
		queue_req(REQ_MOVE, 0, 0, 0, 0, 0, UNIT);
		queue_req(REQ_NONE, W_MIN, W_MIN, 31'h7fffffff, W_MIN, W_MIN, 24'hffffff);
		queue_req(REQ_LOAD, 5 * UNIT, 5 * UNIT, UNIT, W_MIN, W_MAX, 0);
		queue_req(REQ_MOVE, -1, -1, 0, -1, -1, 24'hffffff);
		drain();

		// default walls, random traffic, receiver held off once
		queue_random(380);
		repeat (20) @(posedge clk);
		hold_req <= hold_req + 1;
		drain();

		// widest walls, no idling
		set_walls(W_MIN, W_MAX, W_MIN, W_MAX);
		quiet = 1'b1;
		queue_random(380);
		drain();
		quiet = 1'b0;

		// narrow box around the origin
		set_walls(-10 * UNIT, 10 * UNIT, -10 * UNIT, 10 * UNIT);
		queue_random(380);
		drain();

		// inverted walls
		set_walls(W_MAX, W_MIN, W_MAX, W_MIN);
		queue_random(380);
		drain();

		repeat (DRAIN_WAIT) @(posedge clk);
		if (want_rsp_q.size() != 0) n_errors++;
		$display("ran %0d transactions over four wall settings: %0d wall bounces, %0d reflections",
			n_sent, n_walls, n_reflect);
		$display("%0d results checked, %0d with bounced set, %0d failures",
			n_checked, n_bounced, n_errors);
		if (n_errors == 0) begin
			$display("circle_bounce_step_top test passed");
		end else begin
			$display("circle_bounce_step_top test failed");
		end
		$finish;
	end

endmodule
